// File: rtl/rgb565_to_epaper_packer_top_assert.svh
// ----------------------------------------------------------------------------
// RGB565 to e-paper packer assertion macros
// Shared concurrent assertion forms used by the packer RTL.
// ----------------------------------------------------------------------------
`ifndef RGB565_TO_EPAPER_PACKER_TOP_ASSERT_SVH
`define RGB565_TO_EPAPER_PACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTEPK_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rtepk assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RTEPK_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rtepk assertion failed");

`endif

// File: rtl/rtepk_pkg.sv
// ----------------------------------------------------------------------------
// RGB565 to e-paper packer package
// Shared constants, palette tables, configuration and queue item types.
// ----------------------------------------------------------------------------
`default_nettype none

package rtepk_pkg;

  localparam int PANEL_WIDTH = 2048;
  localparam int STRIDE_1BPP = PANEL_WIDTH / 8;
  localparam int STRIDE_4BPP = PANEL_WIDTH / 2;
  localparam int STRIDE_W    = $clog2(STRIDE_4BPP + 1);

  localparam int PIX_W  = 16;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 11;
  localparam int XY_W   = 11;
  localparam int ADDR_W = 21;
  localparam int DIST_W = 18;
  localparam int PROD_W = (COL_W + STRIDE_W > ADDR_W) ? COL_W + STRIDE_W : ADDR_W;

  localparam logic [7:0] WHITE_LIMIT = 8'd62;
  localparam logic [7:0] TOP_BIT     = 8'h80;
  localparam logic [7:0] CHAN_FULL   = 8'hFF;

  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    REG_DEPTH_MODE    = 3'd0,
    REG_REGION_WIDTH  = 3'd1,
    REG_REGION_HEIGHT = 3'd2,
    REG_REGION_X      = 3'd3,
    REG_REGION_Y      = 3'd4
  } reg_idx_t;

  typedef logic [3:0] code_t;

  localparam int PAL_SIZE = 6;
  // White, green, red, yellow, blue, black.
  localparam code_t      PAL_CODE  [PAL_SIZE] = '{4'h0, 4'h2, 4'h6, 4'hB, 4'hD, 4'hF};
  localparam logic [7:0] PAL_RED   [PAL_SIZE] = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
  localparam logic [7:0] PAL_GREEN [PAL_SIZE] = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
  localparam logic [7:0] PAL_BLUE  [PAL_SIZE] = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0};

  typedef struct packed {
    logic              depth_mode;
    logic [COL_W-1:0]  region_width;
    logic [COL_W-1:0]  region_height;
    logic [XY_W-1:0]   region_x;
    logic [XY_W-1:0]   region_y;
  } cfg_t;

  typedef struct packed {
    logic              depth_mode;
    logic [2:0]        pos;
    logic              emit;
    logic              last;
    code_t             code;
    logic [ADDR_W-1:0] addr;
  } item_t;

  typedef logic [15:0] sq_t;
  typedef sq_t sq32_t [32];
  typedef sq_t sq64_t [64];

  // Squared distance of a widened 5-bit channel to zero or to full scale.
  function automatic sq32_t build_sq5(input bit hi);
    sq32_t t;
    int    v;
    for (int i = 0; i < 32; i++) begin
      v = (i << 3) | (i >> 2);
      if (hi) begin
        v = 255 - v;
      end
      t[i] = 16'(v * v);
    end
    return t;
  endfunction

  // Squared distance of a widened 6-bit channel to zero or to full scale.
  function automatic sq64_t build_sq6(input bit hi);
    sq64_t t;
    int    v;
    for (int i = 0; i < 64; i++) begin
      v = (i << 2) | (i >> 4);
      if (hi) begin
        v = 255 - v;
      end
      t[i] = 16'(v * v);
    end
    return t;
  endfunction

  localparam sq32_t SQ5_LO = build_sq5(1'b0);
  localparam sq32_t SQ5_HI = build_sq5(1'b1);
  localparam sq64_t SQ6_LO = build_sq6(1'b0);
  localparam sq64_t SQ6_HI = build_sq6(1'b1);

endpackage

`default_nettype wire

// File: rtl/rtepk_front.sv
// ----------------------------------------------------------------------------
// Packer front end
// Accepts pixels, tracks row and column position, classifies each pixel and
// computes its byte address, then writes one item per pixel into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb565_to_epaper_packer_top_assert.svh"

module rtepk_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rtepk_pkg::cfg_t                cfg_i,
  input  logic                           push_i,
  input  logic [rtepk_pkg::PIX_W-1:0]    pixel_i,
  output logic                           full_o,
  output logic                           fifo_wr_o,
  output rtepk_pkg::item_t               fifo_item_o,
  input  logic                           fifo_full_i
);
  import rtepk_pkg::*;

  logic              accept;
  logic              advance;
  logic [COL_W-1:0]  col_r, col_nxt, col_inc;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [2:0]        pos;
  logic              row_end;
  logic              emit;
  logic              last;
  logic [4:0]        r5, b5;
  logic [5:0]        g6;
  logic [7:0]        lum;
  logic              white;
  logic [DIST_W-1:0] pal_dist [PAL_SIZE];
  logic [COL_W-1:0]  ysum;
  logic [COL_W-1:0]  colb;

  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_mode_r;
  logic [2:0]        s1_pos_r;
  logic              s1_emit_r;
  logic              s1_last_r;
  logic              s1_white_r;
  logic [DIST_W-1:0] s1_dist_r [PAL_SIZE];
  logic [COL_W-1:0]  s1_ysum_r;
  logic [COL_W-1:0]  s1_colb_r;

  code_t             best_code;
  logic [DIST_W-1:0] near_dist;
  logic [STRIDE_W-1:0] stride;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] addr_sum;

  assign advance = !s1_vld_r || !fifo_full_i;
  assign full_o  = s1_vld_r && fifo_full_i;
  assign accept  = push_i && !full_o;

  // Position of the incoming pixel within its byte and row.
  always_comb begin
    col_inc = col_r + 1'b1;
    row_end = (col_inc == cfg_i.region_width);
    pos     = cfg_i.depth_mode ? {2'b00, col_r[0]} : col_r[2:0];
    emit    = (cfg_i.depth_mode ? col_r[0] : (&col_r[2:0])) || row_end;
    last    = row_end && (({1'b0, row_r} + 1'b1) == cfg_i.region_height);
    if (emit && row_end) begin
      col_nxt = '0;
      row_nxt = last ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_inc;
      row_nxt = row_r;
    end
  end

  // Threshold sum and palette distances. Palette channels are either fully
  // off or fully on, so each channel term is one of two table entries.
  always_comb begin
    r5    = pixel_i[15:11];
    g6    = pixel_i[10:5];
    b5    = pixel_i[4:0];
    lum   = {2'b00, r5, 1'b0} + {2'b00, g6} + {3'b000, b5};
    white = (lum > WHITE_LIMIT);
    for (int i = 0; i < PAL_SIZE; i++) begin
      pal_dist[i] = DIST_W'((PAL_RED[i] == CHAN_FULL) ? SQ5_HI[r5] : SQ5_LO[r5])
                  + DIST_W'((PAL_GREEN[i] == CHAN_FULL) ? SQ6_HI[g6] : SQ6_LO[g6])
                  + DIST_W'((PAL_BLUE[i] == CHAN_FULL) ? SQ5_HI[b5] : SQ5_LO[b5]);
    end
  end

  // Address terms: panel row and byte column.
  always_comb begin
    ysum = {1'b0, cfg_i.region_y} + {1'b0, row_r};
    if (cfg_i.depth_mode) begin
      colb = {2'b00, cfg_i.region_x[XY_W-1:1]} + {1'b0, col_r[COL_W-1:1]};
    end else begin
      colb = {4'h0, cfg_i.region_x[XY_W-1:3]} + {3'b000, col_r[COL_W-1:3]};
    end
  end

  always_comb begin
    if (advance) begin
      s1_vld_nxt = accept;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r  <= cfg_i.depth_mode;
      s1_pos_r   <= pos;
      s1_emit_r  <= emit;
      s1_last_r  <= last;
      s1_white_r <= white;
      s1_dist_r  <= pal_dist;
      s1_ysum_r  <= ysum;
      s1_colb_r  <= colb;
    end
  end

  // Nearest palette entry; a strict compare keeps the earliest entry on ties.
  always_comb begin
    best_code = PAL_CODE[0];
    near_dist = s1_dist_r[0];
    for (int i = 1; i < PAL_SIZE; i++) begin
      if (s1_dist_r[i] < near_dist) begin
        near_dist = s1_dist_r[i];
        best_code = PAL_CODE[i];
      end
    end
  end

  always_comb begin
    stride   = s1_mode_r ? STRIDE_W'(STRIDE_4BPP) : STRIDE_W'(STRIDE_1BPP);
    prod     = PROD_W'(s1_ysum_r) * PROD_W'(stride);
    addr_sum = prod + PROD_W'(s1_colb_r);
  end

  assign fifo_wr_o = s1_vld_r && !fifo_full_i;

  always_comb begin
    fifo_item_o.depth_mode = s1_mode_r;
    fifo_item_o.pos        = s1_pos_r;
    fifo_item_o.emit       = s1_emit_r;
    fifo_item_o.last       = s1_last_r;
    fifo_item_o.code       = s1_mode_r ? best_code : {3'b000, s1_white_r};
    fifo_item_o.addr       = addr_sum[ADDR_W-1:0];
  end

  `RTEPK_ASSERT_NEXT(a_row_end_clears_col, clk, rst_n, accept && row_end, col_r == '0)

endmodule

`default_nettype wire

// File: rtl/rtepk_fifo.sv
// ----------------------------------------------------------------------------
// Packer item queue
// Short first-in first-out queue between the front end and the byte builder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb565_to_epaper_packer_top_assert.svh"

module rtepk_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_i,
  input  rtepk_pkg::item_t  item_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              vld_o,
  output rtepk_pkg::item_t  item_o
);
  import rtepk_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full_o = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign vld_o  = (cnt_r != '0);
  assign item_o = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wr_i ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd_i ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_i && !rd_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i) begin
      mem_r[wptr_r] <= item_i;
    end
  end

  `RTEPK_ASSERT_IMPL(a_no_overflow, clk, rst_n, wr_i, !full_o)
  `RTEPK_ASSERT_IMPL(a_no_underflow, clk, rst_n, rd_i, vld_o)

endmodule

`default_nettype wire

// File: rtl/rtepk_back.sv
// ----------------------------------------------------------------------------
// Packer byte builder
// Merges classified pixel codes into the byte accumulator and hands finished
// bytes with their addresses to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb565_to_epaper_packer_top_assert.svh"

module rtepk_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fifo_vld_i,
  input  rtepk_pkg::item_t               fifo_item_i,
  output logic                           fifo_rd_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [7:0]                     byte_value_o,
  output logic [rtepk_pkg::ADDR_W-1:0]   byte_address_o,
  output logic                           last_o
);
  import rtepk_pkg::*;

  logic              slot_free;
  logic [7:0]        code_bits;
  logic [7:0]        acc_new;
  logic [7:0]        acc_r, acc_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              load_out;
  logic [7:0]        out_byte_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_last_r;

  // A finished byte needs the output register; other pixels only update the
  // accumulator and never wait on the result side.
  assign slot_free = !out_vld_r || pop_i;
  assign fifo_rd_o = fifo_vld_i && (!fifo_item_i.emit || slot_free);
  assign load_out  = fifo_rd_o && fifo_item_i.emit;

  always_comb begin
    if (fifo_item_i.depth_mode) begin
      code_bits = fifo_item_i.pos[0] ? {4'h0, fifo_item_i.code} : {fifo_item_i.code, 4'h0};
    end else begin
      code_bits = fifo_item_i.code[0] ? (TOP_BIT >> fifo_item_i.pos) : 8'h00;
    end
    acc_new = acc_r | code_bits;

    acc_nxt = acc_r;
    if (fifo_rd_o) begin
      acc_nxt = fifo_item_i.emit ? 8'h00 : acc_new;
    end

    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (pop_i) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r <= acc_new;
      out_addr_r <= fifo_item_i.addr;
      out_last_r <= fifo_item_i.last;
    end
  end

  assign empty_o        = !out_vld_r;
  assign byte_value_o   = out_byte_r;
  assign byte_address_o = out_addr_r;
  assign last_o         = out_last_r;

  `RTEPK_ASSERT_IMPL(a_last_is_emit, clk, rst_n, fifo_vld_i && fifo_item_i.last,
                     fifo_item_i.emit)
  `RTEPK_ASSERT_NEXT(a_acc_cleared, clk, rst_n, load_out, acc_r == '0)

endmodule

`default_nettype wire

// File: rtl/rgb565_to_epaper_packer_top.sv
// The pixel completing a byte passes the front register, then the queue, before the byte is
// loaded into the output register that drives the result ports.
// Throughput is one pixel per cycle while full is low; a four-entry queue and the output
// register absorb stalls, and full rises only when the front register and the queue are
// both occupied. Synchronous active-low reset clears position counters, accumulator and
// queue, and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// RGB565 to e-paper packer top level
// Configuration registers, front end, item queue and byte builder.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_to_epaper_packer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtepk_pkg::CFG_AW-1:0]   paddr,
  input  logic [rtepk_pkg::CFG_DW-1:0]   pwdata,
  output logic [rtepk_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready,
  input  logic                           push,
  input  logic [rtepk_pkg::PIX_W-1:0]    in_pixel,
  output logic                           full,
  input  logic                           pop,
  output logic                           empty,
  output logic [7:0]                     out_byte_value,
  output logic [rtepk_pkg::ADDR_W-1:0]   out_byte_address,
  output logic                           out_last_of_region
);
  import rtepk_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic     fifo_wr;
  item_t    fifo_wr_item;
  logic     fifo_full;
  logic     fifo_rd;
  logic     fifo_vld;
  item_t    fifo_rd_item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode    <= 1'b0;
      cfg_r.region_width  <= COL_W'(2048);
      cfg_r.region_height <= COL_W'(1);
      cfg_r.region_x      <= '0;
      cfg_r.region_y      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEPTH_MODE:    cfg_r.depth_mode    <= pwdata[0];
        REG_REGION_WIDTH:  cfg_r.region_width  <= pwdata[COL_W-1:0];
        REG_REGION_HEIGHT: cfg_r.region_height <= pwdata[COL_W-1:0];
        REG_REGION_X:      cfg_r.region_x      <= pwdata[XY_W-1:0];
        REG_REGION_Y:      cfg_r.region_y      <= pwdata[XY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEPTH_MODE:    prdata = CFG_DW'(cfg_r.depth_mode);
      REG_REGION_WIDTH:  prdata = CFG_DW'(cfg_r.region_width);
      REG_REGION_HEIGHT: prdata = CFG_DW'(cfg_r.region_height);
      REG_REGION_X:      prdata = CFG_DW'(cfg_r.region_x);
      REG_REGION_Y:      prdata = CFG_DW'(cfg_r.region_y);
      default:           prdata = '0;
    endcase
  end

  rtepk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .push_i      (push),
    .pixel_i     (in_pixel),
    .full_o      (full),
    .fifo_wr_o   (fifo_wr),
    .fifo_item_o (fifo_wr_item),
    .fifo_full_i (fifo_full)
  );

  rtepk_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (fifo_wr),
    .item_i (fifo_wr_item),
    .full_o (fifo_full),
    .rd_i   (fifo_rd),
    .vld_o  (fifo_vld),
    .item_o (fifo_rd_item)
  );

  rtepk_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_vld_i     (fifo_vld),
    .fifo_item_i    (fifo_rd_item),
    .fifo_rd_o      (fifo_rd),
    .empty_o        (empty),
    .pop_i          (pop),
    .byte_value_o   (out_byte_value),
    .byte_address_o (out_byte_address),
    .last_o         (out_last_of_region)
  );

endmodule

`default_nettype wire
